### sv/lrrc_pkg.sv
// shared types, constants and the crc step for the log record replay checker
package lrrc_pkg;

	localparam int OFFSET_BITS   = 40;
	localparam int HDR_BYTES     = 16;
	localparam int HCOUNT_BITS   = $clog2(HDR_BYTES);
	localparam int KEY_BITS      = 13;
	localparam int VALUE_BITS    = 23;
	localparam int QUEUE_DEPTH   = 2;
	localparam int QUEUE_AW      = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CW      = QUEUE_AW + 1;
	localparam int ADDR_BITS     = 4;

	localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
	localparam logic [31:0] CRC_INIT  = 32'hFFFFFFFF;
	localparam logic [31:0] MAGIC_RST = 32'h574B5652;
	localparam logic [KEY_BITS-1:0]   KEY_MAX   = KEY_BITS'(4 * 1024);
	localparam logic [VALUE_BITS-1:0] VALUE_MAX = VALUE_BITS'(4 * 1024 * 1024);
	localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;

	// register indexes on the config port
	localparam logic [1:0] REG_MAGIC = 2'd0;
	localparam logic [1:0] REG_KEY   = 2'd1;
	localparam logic [1:0] REG_VALUE = 2'd2;

	// result event codes
	localparam logic [2:0] EV_OK       = 3'd0;
	localparam logic [2:0] EV_CLEAN    = 3'd1;
	localparam logic [2:0] EV_BAD      = 3'd2;
	localparam logic [2:0] EV_OVER     = 3'd3;
	localparam logic [2:0] EV_TORN     = 3'd4;
	localparam logic [2:0] EV_CRC      = 3'd5;

	// operations handed from the front to the back
	typedef enum logic [2:0] {
		OP_BYTE      = 3'd0,
		OP_BYTE_LAST = 3'd1,
		OP_EMPTY     = 3'd2,
		OP_END_CLEAN = 3'd3,
		OP_END_TORN  = 3'd4,
		OP_BAD_MAGIC = 3'd5,
		OP_OVER      = 3'd6
	} op_t;

	typedef struct packed {
		logic       mode;
		logic [7:0] data_byte;
	} item_t;

	typedef struct packed {
		logic [2:0]             event_res;
		logic [OFFSET_BITS-1:0] end_offset;
		logic [KEY_BITS-1:0]    key_length;
		logic [VALUE_BITS-1:0]  value_length;
	} result_t;

	typedef struct packed {
		logic [31:0]           magic_word;
		logic [KEY_BITS-1:0]   key_limit;
		logic [VALUE_BITS-1:0] value_limit;
	} cfg_t;

	typedef struct packed {
		op_t                    op;
		logic [7:0]             data_byte;
		logic [OFFSET_BITS-1:0] offset;
		logic [KEY_BITS-1:0]    key_len;
		logic [VALUE_BITS-1:0]  val_bytes;
		logic [31:0]            crc_exp;
	} entry_t;

	// reflected crc-32, one byte
	function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
		logic [31:0] c;
		c = c_in ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
		end
		return c;
	endfunction

endpackage

### sv/log_record_replay_checker_top.sv
// top level of the log record replay checker: config registers and the front/queue/back
//
//   channel   direction  handshake                     payload
//   item      in         item_valid / item_ready       lrrc_pkg::item_t (mode, data_byte)
//   result    out        result_valid / result_ready   lrrc_pkg::result_t
//   config    in         apb psel/penable/pwrite       paddr[3:0], pwdata/prdata 32 bits
//
// one log byte or end marker per cycle while the queue has room; the front classifies
// it when taken; the back does the byte-wide crc update and verdict per queue entry
// a two-entry queue and the result register let input and output stall independently
// reset clears parse state, crc and offsets at once; no clearing pass
// after a failure or the end marker beats are taken and dropped until reset
module log_record_replay_checker_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              item_valid,
	output logic                              item_ready,
	input  lrrc_pkg::item_t                   item,
	output logic                              result_valid,
	input  logic                              result_ready,
	output lrrc_pkg::result_t                 result,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [lrrc_pkg::ADDR_BITS-1:0]    paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready
);

	lrrc_pkg::cfg_t    cfg_q;
	logic              wr_en;
	logic [1:0]        reg_idx;
	logic [lrrc_pkg::KEY_BITS-1:0]   key_wr;
	logic [lrrc_pkg::VALUE_BITS-1:0] value_wr;

	logic              push;
	lrrc_pkg::entry_t  push_entry;
	logic              queue_full;
	logic              pop;
	logic              not_empty;
	lrrc_pkg::entry_t  head;

	// config port
	assign pready   = 1'b1;
	assign wr_en    = psel && penable && pwrite && pready;
	assign reg_idx  = paddr[3:2];
	assign key_wr   = (pwdata[lrrc_pkg::KEY_BITS-1:0] > lrrc_pkg::KEY_MAX) ?
		lrrc_pkg::KEY_MAX : pwdata[lrrc_pkg::KEY_BITS-1:0];
	assign value_wr = (pwdata[lrrc_pkg::VALUE_BITS-1:0] > lrrc_pkg::VALUE_MAX) ?
		lrrc_pkg::VALUE_MAX : pwdata[lrrc_pkg::VALUE_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.magic_word  <= lrrc_pkg::MAGIC_RST;
			cfg_q.key_limit   <= lrrc_pkg::KEY_MAX;
			cfg_q.value_limit <= lrrc_pkg::VALUE_MAX;
		end else if (wr_en) begin
			case (reg_idx)
				lrrc_pkg::REG_MAGIC: cfg_q.magic_word  <= pwdata;
				lrrc_pkg::REG_KEY:   cfg_q.key_limit   <= key_wr;
				lrrc_pkg::REG_VALUE: cfg_q.value_limit <= value_wr;
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		case (reg_idx)
			lrrc_pkg::REG_MAGIC: prdata = cfg_q.magic_word;
			lrrc_pkg::REG_KEY:   prdata = 32'(cfg_q.key_limit);
			lrrc_pkg::REG_VALUE: prdata = 32'(cfg_q.value_limit);
			default:             prdata = '0;
		endcase
	end

	lrrc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.push       (push),
		.push_entry (push_entry),
		.queue_full (queue_full)
	);

	lrrc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (queue_full),
		.pop        (pop),
		.not_empty  (not_empty),
		.head       (head)
	);

	lrrc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.not_empty    (not_empty),
		.head         (head),
		.pop          (pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

### sv/lrrc_front.sv
// front end: header assembly, header checks, payload counting, offset tracking
module lrrc_front (
	input  logic                clk,
	input  logic                arst_n,
	input  lrrc_pkg::cfg_t      cfg,
	input  logic                item_valid,
	output logic                item_ready,
	input  lrrc_pkg::item_t     item,
	output logic                push,
	output lrrc_pkg::entry_t    push_entry,
	input  logic                queue_full
);

	typedef enum logic [2:0] {
		PH_HEADER  = 3'b001,
		PH_PAYLOAD = 3'b010,
		PH_STOPPED = 3'b100
	} phase_t;

	phase_t                                phase_q;
	logic [lrrc_pkg::HCOUNT_BITS-1:0]      count_q;
	logic [31:0]                           words_q [4];
	logic [lrrc_pkg::VALUE_BITS-1:0]       remain_q;
	logic [lrrc_pkg::OFFSET_BITS-1:0]      offset_q;
	logic [lrrc_pkg::KEY_BITS-1:0]         klen_q;
	logic [lrrc_pkg::VALUE_BITS-1:0]       vlen_q;
	logic [31:0]                           crc_exp_q;

	logic                                  take;
	logic [1:0]                            slot;
	logic [31:0]                           word_new;
	logic [lrrc_pkg::OFFSET_BITS-1:0]      offset_nx;
	logic                                  hdr_done;
	logic                                  bad_magic;
	logic                                  over_limit;
	logic [lrrc_pkg::KEY_BITS-1:0]         klen_new;
	logic [lrrc_pkg::VALUE_BITS-1:0]       vlen_new;
	logic [lrrc_pkg::VALUE_BITS-1:0]       sum_new;

	// once stopped, beats are swallowed
	assign item_ready = (phase_q == PH_STOPPED) || !queue_full;
	assign take       = item_valid && item_ready && (phase_q != PH_STOPPED);

	// header word assembly and checks
	assign slot      = count_q[3:2];
	assign word_new  = {item.data_byte, words_q[slot][31:8]};
	assign hdr_done  = (count_q == lrrc_pkg::HCOUNT_BITS'(lrrc_pkg::HDR_BYTES - 1));
	assign bad_magic = (words_q[0] != cfg.magic_word);
	assign over_limit = (words_q[1] > {{(32-lrrc_pkg::KEY_BITS){1'b0}}, cfg.key_limit}) ||
		(words_q[2] > {{(32-lrrc_pkg::VALUE_BITS){1'b0}}, cfg.value_limit});
	assign klen_new  = words_q[1][lrrc_pkg::KEY_BITS-1:0];
	assign vlen_new  = words_q[2][lrrc_pkg::VALUE_BITS-1:0];
	assign sum_new   = lrrc_pkg::VALUE_BITS'(klen_new) + vlen_new;

	// saturating byte offset
	assign offset_nx = (offset_q == lrrc_pkg::OFFSET_MAX) ? offset_q : offset_q + 1'b1;

	// classify the beat into a queue entry
	always_comb begin
		push                 = 1'b0;
		push_entry.op        = lrrc_pkg::OP_BYTE;
		push_entry.data_byte = item.data_byte;
		push_entry.offset    = offset_nx;
		push_entry.key_len   = klen_q;
		push_entry.val_bytes = vlen_q;
		push_entry.crc_exp   = crc_exp_q;
		if (take) begin
			if (item.mode) begin
				push = 1'b1;
				push_entry.op = (phase_q == PH_HEADER && count_q == '0) ?
					lrrc_pkg::OP_END_CLEAN : lrrc_pkg::OP_END_TORN;
			end else if (phase_q == PH_PAYLOAD) begin
				push = 1'b1;
				push_entry.op = (remain_q == lrrc_pkg::VALUE_BITS'(1)) ?
					lrrc_pkg::OP_BYTE_LAST : lrrc_pkg::OP_BYTE;
			end else if (hdr_done) begin
				push_entry.key_len   = klen_new;
				push_entry.val_bytes = vlen_new;
				push_entry.crc_exp   = word_new;
				if (bad_magic) begin
					push = 1'b1;
					push_entry.op = lrrc_pkg::OP_BAD_MAGIC;
				end else if (over_limit) begin
					push = 1'b1;
					push_entry.op = lrrc_pkg::OP_OVER;
				end else if (sum_new == '0) begin
					push = 1'b1;
					push_entry.op = lrrc_pkg::OP_EMPTY;
				end
			end
		end
	end

	// parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEADER;
			count_q  <= '0;
			offset_q <= '0;
			remain_q <= '0;
		end else if (take) begin
			if (item.mode) begin
				phase_q <= PH_STOPPED;
			end else begin
				offset_q <= offset_nx;
				if (phase_q == PH_PAYLOAD) begin
					remain_q <= remain_q - 1'b1;
					if (remain_q == lrrc_pkg::VALUE_BITS'(1)) begin
						phase_q <= PH_HEADER;
					end
				end else begin
					count_q <= count_q + 1'b1;
					if (hdr_done) begin
						remain_q <= sum_new;
						if (bad_magic || over_limit) begin
							phase_q <= PH_STOPPED;
						end else if (sum_new != '0) begin
							phase_q <= PH_PAYLOAD;
						end
					end
				end
			end
		end
	end

	// header words and the record being checked
	always_ff @(posedge clk) begin
		if (take && !item.mode && phase_q == PH_HEADER) begin
			words_q[slot] <= word_new;
			if (hdr_done) begin
				klen_q    <= klen_new;
				vlen_q    <= vlen_new;
				crc_exp_q <= word_new;
			end
		end
	end

endmodule

### sv/lrrc_queue.sv
// short fifo between the front and the back
module lrrc_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  lrrc_pkg::entry_t  push_entry,
	output logic              full,
	input  logic              pop,
	output logic              not_empty,
	output lrrc_pkg::entry_t  head
);

	lrrc_pkg::entry_t                  entries_q [lrrc_pkg::QUEUE_DEPTH];
	logic [lrrc_pkg::QUEUE_AW-1:0]     wr_ptr_q;
	logic [lrrc_pkg::QUEUE_AW-1:0]     rd_ptr_q;
	logic [lrrc_pkg::QUEUE_CW-1:0]     count_q;

	assign full      = (count_q == lrrc_pkg::QUEUE_CW'(lrrc_pkg::QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = entries_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == lrrc_pkg::QUEUE_AW'(lrrc_pkg::QUEUE_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == lrrc_pkg::QUEUE_AW'(lrrc_pkg::QUEUE_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

### sv/lrrc_back.sv
// back end: crc over the payload, record verdicts and the result register
module lrrc_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              not_empty,
	input  lrrc_pkg::entry_t  head,
	output logic              pop,
	output logic              result_valid,
	input  logic              result_ready,
	output lrrc_pkg::result_t result
);

	logic [31:0]                       crc_q;
	logic [lrrc_pkg::OFFSET_BITS-1:0]  good_end_q;
	logic                              stopped_q;
	logic                              res_valid_q;
	lrrc_pkg::result_t                 res_q;

	logic [31:0]                       crc_nx;
	logic                              crc_ok;
	logic                              work;
	logic [2:0]                        ev_nx;

	assign result_valid = res_valid_q;
	assign result       = res_q;

	// pop when the result slot can take whatever this entry makes
	assign pop  = not_empty && (stopped_q || !res_valid_q || result_ready);
	assign work = pop && !stopped_q;

	assign crc_nx = (head.op == lrrc_pkg::OP_EMPTY) ? crc_q :
		lrrc_pkg::crc_byte(crc_q, head.data_byte);
	assign crc_ok = (~crc_nx == head.crc_exp);

	// event code for the head entry
	always_comb begin
		case (head.op)
			lrrc_pkg::OP_BYTE_LAST, lrrc_pkg::OP_EMPTY: begin
				ev_nx = crc_ok ? lrrc_pkg::EV_OK : lrrc_pkg::EV_CRC;
			end
			lrrc_pkg::OP_END_CLEAN: ev_nx = lrrc_pkg::EV_CLEAN;
			lrrc_pkg::OP_END_TORN:  ev_nx = lrrc_pkg::EV_TORN;
			lrrc_pkg::OP_BAD_MAGIC: ev_nx = lrrc_pkg::EV_BAD;
			lrrc_pkg::OP_OVER:      ev_nx = lrrc_pkg::EV_OVER;
			default:                ev_nx = lrrc_pkg::EV_TORN;
		endcase
	end

	// control and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q       <= lrrc_pkg::CRC_INIT;
			good_end_q  <= '0;
			stopped_q   <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (work && head.op != lrrc_pkg::OP_BYTE) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && result_ready) begin
				res_valid_q <= 1'b0;
			end
			if (work) begin
				case (head.op)
					lrrc_pkg::OP_BYTE: begin
						crc_q <= crc_nx;
					end
					lrrc_pkg::OP_BYTE_LAST, lrrc_pkg::OP_EMPTY: begin
						crc_q <= lrrc_pkg::CRC_INIT;
						if (crc_ok) begin
							good_end_q <= head.offset;
						end else begin
							stopped_q <= 1'b1;
						end
					end
					default: begin
						stopped_q <= 1'b1;
					end
				endcase
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (work && head.op != lrrc_pkg::OP_BYTE) begin
			res_q.event_res <= ev_nx;
			if (ev_nx == lrrc_pkg::EV_OK) begin
				res_q.end_offset   <= head.offset;
				res_q.key_length   <= head.key_len;
				res_q.value_length <= head.val_bytes;
			end else begin
				res_q.end_offset   <= good_end_q;
				res_q.key_length   <= '0;
				res_q.value_length <= '0;
			end
		end
	end

endmodule

### tb/tb_log_record_replay_checker_top.sv
// self-checking testbench for the log record replay checker top level
module tb_log_record_replay_checker_top;
	timeunit 1ns;
	timeprecision 1ps;

	import lrrc_pkg::*;

	localparam int          CYCLE_LIMIT = 200000;
	localparam int          HOLD_CYCLES = 400;
	localparam logic [1:0]  REG_SPARE   = 2'd3;

	// parser position of the predicted block
	typedef enum logic [1:0] {ST_HEADER, ST_PAYLOAD, ST_STOPPED} parse_t;

	// how the log is closed at the end of the run
	typedef enum int {
		CLOSE_CLEAN, CLOSE_TORN_HEADER, CLOSE_TORN_PAYLOAD, CLOSE_BAD_MAGIC,
		CLOSE_OVER_LIMIT, CLOSE_CRC, CLOSE_BAD_AND_OVER
	} close_t;

	// log parser prediction and in-order result check
	class replay_scoreboard;
		logic [31:0]            magic;
		logic [KEY_BITS-1:0]    klim;
		logic [VALUE_BITS-1:0]  vlim;
		parse_t                 st;
		logic [4:0]             hcnt;
		logic [31:0]            hw [4];
		logic [31:0]            remain;
		logic [31:0]            crc;
		logic [OFFSET_BITS-1:0] offs;
		logic [OFFSET_BITS-1:0] good_end;
		result_t                pending_q [$];
		int                     errors;
		int                     records_ok;

		function new();
			magic = MAGIC_RST;
			klim = KEY_MAX;
			vlim = VALUE_MAX;
			st = ST_HEADER;
			hcnt = '0;
			foreach (hw[i]) hw[i] = '0;
			remain = '0;
			crc = CRC_INIT;
			offs = '0;
			good_end = '0;
			errors = 0;
			records_ok = 0;
		endfunction

		// reflected crc-32 over one byte
		function logic [31:0] crc_step(input logic [31:0] c_in, input logic [7:0] b);
			logic [31:0] c;
			c = c_in ^ {24'd0, b};
			repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
			return c;
		endfunction

		function void set_reg(input logic [1:0] idx, input logic [31:0] v);
			case (idx)
				REG_MAGIC: magic = v;
				REG_KEY: klim = (v[KEY_BITS-1:0] > KEY_MAX) ? KEY_MAX : v[KEY_BITS-1:0];
				REG_VALUE: begin
					vlim = (v[VALUE_BITS-1:0] > VALUE_MAX) ? VALUE_MAX : v[VALUE_BITS-1:0];
				end
				default: ;
			endcase
		endfunction

		function logic [31:0] reg_value(input logic [1:0] idx);
			case (idx)
				REG_MAGIC: return magic;
				REG_KEY: return {{(32-KEY_BITS){1'b0}}, klim};
				default: return {{(32-VALUE_BITS){1'b0}}, vlim};
			endcase
		endfunction

		function void expect_event(input logic [2:0] ev, input logic [31:0] kl,
				input logic [31:0] vl);
			result_t r;
			r.event_res = ev;
			r.end_offset = good_end;
			r.key_length = kl[KEY_BITS-1:0];
			r.value_length = vl[VALUE_BITS-1:0];
			pending_q.push_back(r);
		endfunction

		// last payload byte or empty record: compare crc, record ok or stop
		function void close_record();
			st = ST_HEADER;
			hcnt = '0;
			if (~crc != hw[3]) begin
				crc = CRC_INIT;
				st = ST_STOPPED;
				expect_event(EV_CRC, 0, 0);
				return;
			end
			crc = CRC_INIT;
			good_end = offs;
			records_ok++;
			expect_event(EV_OK, hw[1], hw[2]);
		endfunction

		// one accepted input beat
		function void note_item(input item_t it);
			logic [1:0] slot;
			if (st == ST_STOPPED) return;
			if (it.mode) begin
				expect_event((st == ST_HEADER && hcnt == 0) ? EV_CLEAN : EV_TORN, 0, 0);
				st = ST_STOPPED;
				return;
			end
			if (offs != OFFSET_MAX) offs = offs + 1'b1;
			if (st == ST_PAYLOAD) begin
				crc = crc_step(crc, it.data_byte);
				if (remain > 0) remain = remain - 1;
				if (remain == 0) close_record();
				return;
			end
			// header bytes fill four little-endian words
			slot = hcnt[3:2];
			hw[slot] = {it.data_byte, hw[slot][31:8]};
			hcnt = hcnt + 1'b1;
			if (hcnt < HDR_BYTES) return;
			hcnt = '0;
			if (hw[0] != magic) begin
				st = ST_STOPPED;
				expect_event(EV_BAD, 0, 0);
				return;
			end
			if (hw[1] > {19'd0, klim} || hw[2] > {9'd0, vlim}) begin
				st = ST_STOPPED;
				expect_event(EV_OVER, 0, 0);
				return;
			end
			crc = CRC_INIT;
			remain = hw[1] + hw[2];
			if (remain == 0) close_record();
			else st = ST_PAYLOAD;
		endfunction

		task report(input string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			errors++;
		endtask

		// one accepted output beat against the oldest expectation
		task check_result(input result_t got);
			result_t want;
			if (pending_q.size() == 0) begin
				report($sformatf("result with nothing expected, event %0d", got.event_res));
				return;
			end
			want = pending_q.pop_front();
			if (got.event_res !== want.event_res)
				report($sformatf("event_res %0d, want %0d", got.event_res, want.event_res));
			if (got.end_offset !== want.end_offset)
				report($sformatf("end_offset %0d, want %0d", got.end_offset, want.end_offset));
			if (got.key_length !== want.key_length)
				report($sformatf("key_length %0d, want %0d", got.key_length, want.key_length));
			if (got.value_length !== want.value_length)
				report($sformatf("value_length %0d, want %0d",
					got.value_length, want.value_length));
		endtask
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 item_valid;
	logic                 item_ready;
	item_t                item;
	logic                 result_valid;
	logic                 result_ready;
	result_t              result;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [ADDR_BITS-1:0] paddr;
	logic [31:0]          pwdata;
	logic [31:0]          prdata;
	logic                 pready;

	replay_scoreboard sb = new();
	int               cycles = 0;
	int               bytes_sent = 0;
	bit               steady = 0;
	bit               hold_req = 0;
	close_t           closing;

	log_record_replay_checker_top u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	// clock
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("log_record_replay_checker_top verification failed");
			$finish;
		end
	end

	// beat monitor on both channels
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && item_ready) sb.note_item(item);
			if (result_valid && result_ready) sb.check_result(result);
		end
	end

	// result receiver: random stalls, quiet stretch, one long hold-off
	initial begin
		result_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 0;
				result_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			result_ready <= steady || ($urandom_range(0, 99) >= 6);
		end
	end

	// offer one beat and wait for it to be taken
	task automatic push_item(input item_t it);
		if (!steady && $urandom_range(0, 99) < 6) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		item <= it;
		item_valid <= 1'b1;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
	endtask

	task automatic send_byte(input logic [7:0] b);
		item_t it;
		it.mode = 1'b0;
		it.data_byte = b;
		bytes_sent++;
		push_item(it);
	endtask

	task automatic send_end();
		item_t it;
		it.mode = 1'b1;
		it.data_byte = 8'($urandom);
		push_item(it);
	endtask

	// header plus random payload; cut below the full size tears the record
	task automatic send_record(input logic [31:0] mword, input logic [31:0] klen,
			input logic [31:0] vlen, input logic [31:0] crc_flip, input int cut);
		logic [7:0]  pay [$];
		logic [31:0] c;
		logic [31:0] words [4];
		logic [7:0]  b;
		int          total;
		c = CRC_INIT;
		if (cut < 0 || cut > HDR_BYTES) begin
			for (int i = 0; i < klen + vlen; i++) begin
				pay.push_back(8'($urandom));
				c = sb.crc_step(c, pay[i]);
			end
		end
		words[0] = mword;
		words[1] = klen;
		words[2] = vlen;
		words[3] = ~c ^ crc_flip;
		total = HDR_BYTES + pay.size();
		if (cut >= 0 && cut < total) total = cut;
		for (int n = 0; n < total; n++) begin
			b = (n < HDR_BYTES) ? words[n / 4][8 * (n % 4) +: 8] : pay[n - HDR_BYTES];
			send_byte(b);
		end
	endtask

	// record length: mostly short, sometimes zero or right at the limit
	function automatic logic [31:0] pick_len(input logic [31:0] lim, input int unsigned cap);
		int unsigned roll;
		logic [31:0] top;
		roll = $urandom_range(0, 99);
		top = (lim < cap) ? lim : cap;
		if (lim == 0 || roll < 12) return 0;
		if (roll < 24 && lim <= 64) return lim;
		if (roll < 27 && lim >= 300) return $urandom_range(100, 300);
		return $urandom_range(0, top);
	endfunction

	task automatic run_records(input int budget);
		int start;
		start = bytes_sent;
		while (bytes_sent - start < budget)
			send_record(sb.magic, pick_len({19'd0, sb.klim}, 12),
				pick_len({9'd0, sb.vlim}, 24), 0, -1);
	endtask

	// drain everything outstanding, then let the pipeline empty
	task automatic quiesce();
		item_valid <= 1'b0;
		while (sb.pending_q.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic apb_write(input logic [1:0] idx, input logic [31:0] d);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= d;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		sb.set_reg(idx, d);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apb_check(input logic [1:0] idx);
		logic [31:0] got;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		got = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		if (got !== sb.reg_value(idx))
			sb.report($sformatf("register %0d reads %h, want %h", idx, got, sb.reg_value(idx)));
	endtask

	task automatic apply_setting(input logic [31:0] m, input logic [31:0] k,
			input logic [31:0] v);
		apb_write(REG_MAGIC, m);
		apb_write(REG_KEY, k);
		apb_write(REG_VALUE, v);
		apb_check(REG_MAGIC);
		apb_check(REG_KEY);
		apb_check(REG_VALUE);
	endtask

	// final record or marker that stops the replay
	task automatic close_log(input close_t kind);
		logic [31:0] kl;
		logic [31:0] vl;
		kl = $urandom_range(0, 10);
		vl = $urandom_range(1, 20);
		case (kind)
			CLOSE_CLEAN: send_end();
			CLOSE_TORN_HEADER: begin
				send_record(sb.magic, kl, vl, 0, $urandom_range(1, HDR_BYTES - 1));
				send_end();
			end
			CLOSE_TORN_PAYLOAD: begin
				send_record(sb.magic, kl, vl, 0,
					HDR_BYTES + $urandom_range(0, kl + vl - 1));
				send_end();
			end
			CLOSE_BAD_MAGIC:
				send_record(sb.magic ^ (32'd1 << $urandom_range(0, 31)), kl, vl, 0,
					HDR_BYTES);
			CLOSE_OVER_LIMIT: begin
				case ($urandom_range(0, 2))
					0: kl = {19'd0, sb.klim} + 1;
					1: vl = {9'd0, sb.vlim} + 1;
					default: kl = {1'b1, 31'($urandom)};
				endcase
				send_record(sb.magic, kl, vl, 0, HDR_BYTES);
			end
			CLOSE_CRC:
				send_record(sb.magic, kl, vl, 32'd1 << $urandom_range(0, 31), -1);
			default:
				send_record(~sb.magic, {1'b1, 31'($urandom)}, vl, 0, HDR_BYTES);
		endcase
	endtask

	// main sequence
	initial begin
		item_t noise;
		arst_n <= 1'b0;
		item_valid <= 1'b0;
		item <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty record then a short one under reset limits
		send_record(MAGIC_RST, 0, 0, 0, -1);
		send_record(MAGIC_RST, 1, 1, 0, -1);
		run_records(320);
		quiesce();

		// zero limits: only empty records pass; a write beyond the list is dropped
		apb_write(REG_SPARE, $urandom);
		apply_setting($urandom, 0, 0);
		run_records(96);
		quiesce();

		// all-zero magic, key limit saturates, value limit tiny
		apply_setting(32'h0000_0000, 32'hFFFF_FFFF, 5);
		run_records(300);
		quiesce();

		// all-ones magic, masked key limit, value limit saturates; no idling here
		apply_setting(32'hFFFF_FFFF, 32'h0001_0007, 32'hFFFF_FFFF);
		steady = 1;
		run_records(300);
		quiesce();
		steady = 0;

		// random limits, with the receiver holding off long enough to back up the input
		apply_setting($urandom, $urandom_range(0, 20), $urandom_range(0, 40));
		hold_req = 1;
		run_records(300);
		quiesce();

		// back to reset values, then the closing event and ignored trailing beats
		apply_setting(MAGIC_RST, KEY_MAX, VALUE_MAX);
		run_records(200);
		closing = close_t'($urandom_range(0, 6));
		close_log(closing);
		repeat (24) begin
			noise.mode = 1'($urandom);
			noise.data_byte = 8'($urandom);
			push_item(noise);
		end

		quiesce();
		repeat (20) @(posedge clk);
		$display("covered %0d log bytes, %0d records passed over six register settings",
			bytes_sent, sb.records_ok);
		$display("log closed by %s, then trailing beats while stopped", closing.name());
		if (sb.errors == 0) begin
			$display("log_record_replay_checker_top verification clean");
		end else begin
			$display("log_record_replay_checker_top verification failed");
		end
		$finish;
	end

endmodule

### filelist.f
sv/lrrc_pkg.sv
sv/lrrc_front.sv
sv/lrrc_queue.sv
sv/lrrc_back.sv
sv/log_record_replay_checker_top.sv
tb/tb_log_record_replay_checker_top.sv
